/* rtl/tgc_pkg.sv */
// shared types and constants for the touch gesture classifier
// no dependencies
`default_nettype none

package tgc_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FIELD_BITS     = 12;
	localparam int EXT_BITS       = 16;
	localparam int TIME_BITS      = 32;
	localparam int MAX_TIME_BITS  = 16;

	localparam logic [FIELD_BITS-1:0]    SWIPE_MIN_RST = 12'd30;
	localparam logic [MAX_TIME_BITS-1:0] MAX_TIME_RST  = 16'd1500;

	typedef enum logic [0:0] {
		REG_SWIPE_MIN_TRAVEL = 1'b0,
		REG_MAX_GESTURE_TIME = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_TAP  = 2'd1,
		EV_UP   = 2'd2,
		EV_DOWN = 2'd3
	} event_t;

endpackage

`default_nettype wire

/* rtl/tgc_classify.sv */
// gesture decision on release: swipe direction or tap
// depends on tgc_pkg
`default_nettype none

module tgc_classify import tgc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] last_x,
	input  wire logic [COORD_BITS-1:0] last_y,
	input  wire logic [FIELD_BITS-1:0] min_travel,
	input  wire logic                  time_ok,
	output event_t                     gesture
);

	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic [EXT_BITS-1:0]   adx_ext;
	logic [EXT_BITS-1:0]   ady_ext;
	logic [EXT_BITS-1:0]   min_ext;
	logic                  dx_neg;
	logic                  dy_neg;

	assign dx_neg  = last_x < start_x;
	assign dy_neg  = last_y < start_y;
	assign adx     = dx_neg ? start_x - last_x : last_x - start_x;
	assign ady     = dy_neg ? start_y - last_y : last_y - start_y;
	assign adx_ext = {{(EXT_BITS-COORD_BITS){1'b0}}, adx};
	assign ady_ext = {{(EXT_BITS-COORD_BITS){1'b0}}, ady};
	assign min_ext = {{(EXT_BITS-FIELD_BITS){1'b0}}, min_travel};

	always_comb begin
		gesture = EV_TAP;
		if (time_ok) begin
			if (ady_ext >= min_ext && ady >= adx) begin
				gesture = dy_neg ? EV_UP : EV_DOWN;
			end else if (adx_ext >= min_ext && adx > ady) begin
				gesture = dx_neg ? EV_UP : EV_DOWN;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/touch_gesture_classifier_core.sv */
// touch gesture classifier top level: input register, touch tracking, result register
// depends on tgc_pkg and tgc_classify
//
// channel  dir  handshake         payload
// s_       in   s_tvalid/tready   tuser: pressed; tdata: sample_x, sample_y, now_ms
// m_       out  m_tvalid/tready   tuser: event_res; tdata: pos_x, pos_y, touching, position_valid
// cfg_     in   cfg_valid/ready   cfg_index, cfg_data (always ready)
//
// one word per cycle sustained while the output is not stalled; a word is captured in the
// input register and its result is written from there into the output register
// the touch state updates once per word as it leaves the input register
// a stalled output holds its word while one more input word waits in the input register
// reset clears the touch state and loads the default thresholds
`default_nettype none

module touch_gesture_classifier_core import tgc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [55:0]              s_tdata,   // sample_x, sample_y, now_ms
	input  wire logic                     s_tuser,   // pressed
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [31:0]                   m_tdata,   // pos_x, pos_y, touching, position_valid, zeros
	output logic [1:0]                    m_tuser,   // event_res
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [0:0]               cfg_index,
	input  wire logic [MAX_TIME_BITS-1:0] cfg_data
);

	logic                    valid_s1;
	logic                    pressed_s1;
	logic [FIELD_BITS-1:0]   x_s1;
	logic [FIELD_BITS-1:0]   y_s1;
	logic [TIME_BITS-1:0]    now_s1;
	logic                    adv_s1;

	logic [FIELD_BITS-1:0]    min_travel_q;
	logic [MAX_TIME_BITS-1:0] max_time_q;

	logic                  touch_down_q;
	logic                  have_pos_q;
	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic [TIME_BITS-1:0]  start_time_q;

	logic [COORD_BITS-1:0] sx;
	logic [COORD_BITS-1:0] sy;
	logic [EXT_BITS-1:0]   sx_ext;
	logic [EXT_BITS-1:0]   sy_ext;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  time_ok;
	event_t                gesture;

	logic                  touch_down_d;
	logic                  have_pos_d;
	logic [COORD_BITS-1:0] last_x_d;
	logic [COORD_BITS-1:0] last_y_d;
	logic [EXT_BITS-1:0]   pos_x_ext;
	logic [EXT_BITS-1:0]   pos_y_ext;
	event_t                event_d;

	// handshakes
	assign adv_s1    = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pressed_s1 <= s_tuser;
			x_s1       <= s_tdata[11:0];
			y_s1       <= s_tdata[23:12];
			now_s1     <= s_tdata[55:24];
		end
	end

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_travel_q <= SWIPE_MIN_RST;
			max_time_q   <= MAX_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_SWIPE_MIN_TRAVEL: min_travel_q <= cfg_data[FIELD_BITS-1:0];
				REG_MAX_GESTURE_TIME: max_time_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// coordinates kept to COORD_BITS
	assign sx_ext = {{(EXT_BITS-FIELD_BITS){1'b0}}, x_s1};
	assign sy_ext = {{(EXT_BITS-FIELD_BITS){1'b0}}, y_s1};
	assign sx     = sx_ext[COORD_BITS-1:0];
	assign sy     = sy_ext[COORD_BITS-1:0];

	assign elapsed = now_s1 - start_time_q;
	assign time_ok = elapsed <= {{(TIME_BITS-MAX_TIME_BITS){1'b0}}, max_time_q};

	tgc_classify #(
		.COORD_BITS(COORD_BITS)
	) u_classify (
		.start_x   (start_x_q),
		.start_y   (start_y_q),
		.last_x    (last_x_q),
		.last_y    (last_y_q),
		.min_travel(min_travel_q),
		.time_ok   (time_ok),
		.gesture   (gesture)
	);

	always_comb begin
		touch_down_d = touch_down_q;
		have_pos_d   = have_pos_q;
		last_x_d     = last_x_q;
		last_y_d     = last_y_q;
		event_d      = EV_NONE;
		if (pressed_s1) begin
			touch_down_d = 1'b1;
			have_pos_d   = 1'b1;
			last_x_d     = sx;
			last_y_d     = sy;
		end else if (touch_down_q) begin
			touch_down_d = 1'b0;
			event_d      = gesture;
		end
	end

	// touch tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_down_q <= 1'b0;
			have_pos_q   <= 1'b0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			start_time_q <= '0;
		end else if (adv_s1) begin
			touch_down_q <= touch_down_d;
			have_pos_q   <= have_pos_d;
			last_x_q     <= last_x_d;
			last_y_q     <= last_y_d;
			if (pressed_s1 && !touch_down_q) begin
				start_x_q    <= sx;
				start_y_q    <= sy;
				start_time_q <= now_s1;
			end
		end
	end

	// result register
	assign pos_x_ext = {{(EXT_BITS-COORD_BITS){1'b0}}, last_x_d};
	assign pos_y_ext = {{(EXT_BITS-COORD_BITS){1'b0}}, last_y_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tuser <= event_d;
			m_tdata <= {6'd0, have_pos_d, touch_down_d,
				pos_y_ext[FIELD_BITS-1:0], pos_x_ext[FIELD_BITS-1:0]};
		end
	end

	// checks
	a_event_ends_touch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_NONE |-> !m_tdata[24])
		else $error("gesture reported while touch still active");

	a_touch_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		touch_down_q |-> have_pos_q)
		else $error("touch in progress without a recorded position");

	a_no_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[25] |-> m_tdata[23:0] == 24'd0 && m_tuser == EV_NONE)
		else $error("position or event reported before any touch");

endmodule

`default_nettype wire
